@@ hdl/dsm_pkg.sv @@
// shared types and constants of the drum step sequencer mixer
package dsm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 25;
  localparam int LEN_W    = 17;
  localparam int STEP_W   = 4;
  localparam int OFF_W    = 20;
  localparam int CFG_W    = 16;

  localparam logic [15:0] BEAT_LENGTH_RESET     = 16'd10285;
  localparam logic [7:0]  SEQUENCE_LENGTH_RESET = 8'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MIX_W-1:0]    mix_t;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_PAD_TRIGGER  = 3'd1,
    OP_PLAY_TOGGLE  = 3'd2,
    OP_SAMPLE_WORD  = 3'd3,
    OP_SAMPLE_LEN   = 3'd4,
    OP_PATTERN_STEP = 3'd5,
    OP_SEQ_ENTRY    = 3'd6
  } op_t;

  typedef enum logic {
    CFG_BEAT_LENGTH     = 1'b0,
    CFG_SEQUENCE_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEQ,
    ST_HIT,
    ST_VOICE,
    ST_FLUSH,
    ST_DONE,
    ST_CLEAR
  } state_t;

endpackage

@@ hdl/dsm_sample_ram.sv @@
// sample word memory, one write and one registered read port
module dsm_sample_ram #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  dsm_pkg::sample_t           wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output dsm_pkg::sample_t           rd_data
);
  import dsm_pkg::*;

  sample_t mem [DEPTH];
  sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/drum_step_sequencer_mixer.sv @@
// top level of the drum step sequencer mixer
//
// Usage: an operation is accepted when start is high and busy is low. Loads
// (sample word, length, pattern step, sequence entry), pad triggers and the
// play toggle finish in the accept cycle; busy stays low. A tick sets busy and
// walks the state held in memories; while playing, one sequence read, then for
// each of the 16 step offsets one pattern read and one sample lookup per
// instrument whose step bit is set and whose sample is long enough, then one
// lookup per active pad voice; while stopped, only the pad voice lookups. The
// sample memory has a single read port, so the lookups are made one after
// another; busy drops in the cycle after the result.
// The result (out_mix_value, out_current_step, out_playing) is shown for one
// cycle with out_valid high; the receiver cannot stall, it must take it then.
// Only a tick gives a result.
// Configuration writes (beat length, sequence length) use cfg_valid/cfg_ready
// and are taken at once; write them only while the block is idle.
// Reset (rst_n low, synchronous) stops play, clears counters, pad voices and
// lengths; then a clearing pass over max(16*NUM_PATTERNS, SEQUENCE_DEPTH) addresses
// (256 by default) holds busy high while it zeroes patterns and the sequence.
module drum_step_sequencer_mixer #(
  parameter int NUM_INSTRUMENTS = 16,
  parameter int SAMPLE_DEPTH    = 65536,
  parameter int SEQUENCE_DEPTH  = 128,
  parameter int NUM_PATTERNS    = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_operation,
  input  logic [3:0]              in_instrument,
  input  logic [15:0]             in_sample_address,
  input  dsm_pkg::sample_t        in_sample_value,
  input  logic [16:0]             in_sample_length,
  input  logic [3:0]              in_pattern_slot,
  input  logic [3:0]              in_step_index,
  input  logic [15:0]             in_step_mask,
  input  logic [6:0]              in_sequence_index,
  input  logic [3:0]              in_sequence_pattern,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [dsm_pkg::CFG_W-1:0] cfg_data,
  output logic                    out_valid,
  output dsm_pkg::mix_t           out_mix_value,
  output logic [3:0]              out_current_step,
  output logic                    out_playing
);
  import dsm_pkg::*;

  localparam int IW     = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int SMP_DEPTH = NUM_INSTRUMENTS * SAMPLE_DEPTH;
  localparam int SM_AW  = $clog2(SMP_DEPTH);
  localparam int PAT_DEPTH = NUM_PATTERNS * 16;
  localparam int PA_W   = $clog2(PAT_DEPTH);
  localparam int SQ_AW  = (SEQUENCE_DEPTH > 1) ? $clog2(SEQUENCE_DEPTH) : 1;
  localparam int CLR_DEPTH = (PAT_DEPTH > SEQUENCE_DEPTH) ? PAT_DEPTH : SEQUENCE_DEPTH;
  localparam int CLR_W  = $clog2(CLR_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);
  localparam logic [IW-1:0]    I_LAST   = IW'(NUM_INSTRUMENTS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(SAMPLE_DEPTH);
  localparam logic [7:0]       SEQ_MAX  = 8'(SEQUENCE_DEPTH);
  localparam logic [4:0]       PAT_NUM  = 5'(NUM_PATTERNS);
  localparam logic [4:0]       INS_NUM  = 5'(NUM_INSTRUMENTS);

  state_t state_r, state_nxt;

  // control and counters
  logic              play_r;
  logic              tick_play_r;
  logic [15:0]       pulse_r;
  logic [STEP_W-1:0] step_r;
  logic [6:0]        seq_pos_r;
  logic [15:0]       beat_r;
  logic [7:0]        seq_len_r;
  logic [STEP_W-1:0] shown_step_r;
  logic [STEP_W-1:0] j_r;
  logic [IW-1:0]     i_r;
  logic [OFF_W-1:0]  off_r;
  logic [3:0]        pat_r;
  logic              pend_r;
  mix_t              acc_r;
  logic [CLR_W-1:0]  clr_r;

  logic [LEN_W-1:0]  len_r [NUM_INSTRUMENTS];
  logic [LEN_W-1:0]  pos_r [NUM_INSTRUMENTS];
  logic              act_r [NUM_INSTRUMENTS];

  // pattern and sequence memories, zeroed by the pass after reset
  logic [15:0]       pat_mem [PAT_DEPTH];
  logic [15:0]       mask_q_r;
  logic [3:0]        seq_mem [SEQUENCE_DEPTH];
  logic [3:0]        seq_q_r;

  logic              accept;
  op_t               op;
  logic              i_last;
  logic [3:0]        pat_sel;
  logic              pat_ok;
  logic              seq_rd;
  logic              pat_rd;
  logic [STEP_W-1:0] pat_step;
  logic [PA_W-1:0]   pat_rd_addr;
  logic              clearing;
  logic              pat_wr;
  logic [PA_W-1:0]   pat_wr_addr;
  logic [15:0]       pat_wr_data;
  logic              seq_wr;
  logic [SQ_AW-1:0]  seq_wr_addr;
  logic [3:0]        seq_wr_data;
  logic [IW-1:0]     len_idx;
  logic [LEN_W-1:0]  len_rd;
  logic              hit;
  logic              voice_rd;
  logic              smp_rd;
  logic [OFF_W-1:0]  smp_off;
  logic [SM_AW-1:0]  smp_rd_addr;
  logic [SM_AW-1:0]  smp_wr_addr;
  logic              smp_wr;
  sample_t           smp_q;
  logic              advance;
  logic [7:0]        eff_len;

  assign op      = op_t'(in_operation);
  assign i_last  = (i_r == I_LAST);
  assign pat_sel = seq_q_r;
  assign pat_ok  = ({1'b0, pat_sel} < PAT_NUM);
  assign len_idx = busy ? i_r : in_instrument[IW-1:0];
  assign len_rd  = len_r[len_idx];

  always_comb begin
    eff_len = seq_len_r;
    if (eff_len == 8'd0) begin
      eff_len = 8'd1;
    end
    if (eff_len > SEQ_MAX) begin
      eff_len = SEQ_MAX;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && op == OP_TICK) begin
          state_nxt = play_r ? ST_SEQ : ST_VOICE;
        end
      end
      ST_SEQ: begin
        state_nxt = pat_ok ? ST_HIT : ST_VOICE;
      end
      ST_HIT: begin
        if (i_last && j_r == 4'hF) begin
          state_nxt = ST_VOICE;
        end
      end
      ST_VOICE: begin
        if (i_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy      = (state_r != ST_IDLE);
    accept    = start && (state_r == ST_IDLE);
    out_valid = (state_r == ST_DONE);
    advance   = (state_r == ST_DONE) && tick_play_r;
    clearing  = (state_r == ST_CLEAR);
    seq_rd    = accept && op == OP_TICK && play_r;
    pat_rd    = (state_r == ST_SEQ && pat_ok) ||
                (state_r == ST_HIT && i_last && j_r != 4'hF);
    pat_step  = step_r - ((state_r == ST_SEQ) ? 4'd0 : j_r + 4'd1);
    pat_rd_addr = PA_W'({4'd0, ((state_r == ST_SEQ) ? pat_sel : pat_r), 4'd0}
                        + {8'd0, pat_step});
    pat_wr    = clearing ? (32'(clr_r) < PAT_DEPTH) :
                (accept && op == OP_PATTERN_STEP && ({1'b0, in_pattern_slot} < PAT_NUM));
    pat_wr_addr = clearing ? PA_W'(clr_r) :
                  PA_W'({4'd0, in_pattern_slot, 4'd0} + {8'd0, in_step_index});
    pat_wr_data = clearing ? 16'd0 : in_step_mask;
    seq_wr    = clearing ? (32'(clr_r) < SEQUENCE_DEPTH) :
                (accept && op == OP_SEQ_ENTRY && 32'(in_sequence_index) < SEQUENCE_DEPTH);
    seq_wr_addr = clearing ? SQ_AW'(clr_r) : in_sequence_index[SQ_AW-1:0];
    seq_wr_data = clearing ? 4'd0 : in_sequence_pattern;
    hit       = (state_r == ST_HIT) && mask_q_r[i_r] && (off_r < OFF_W'(len_rd));
    voice_rd  = (state_r == ST_VOICE) && act_r[i_r];
    smp_rd    = hit || voice_rd;
    smp_off   = (state_r == ST_HIT) ? off_r : OFF_W'(pos_r[i_r]);
    smp_rd_addr = SM_AW'(32'(i_r) * SAMPLE_DEPTH + 32'(smp_off));
    smp_wr    = accept && op == OP_SAMPLE_WORD &&
                ({1'b0, in_instrument} < INS_NUM) &&
                (32'(in_sample_address) < SAMPLE_DEPTH);
    smp_wr_addr = SM_AW'(32'(in_instrument) * SAMPLE_DEPTH + 32'(in_sample_address));
  end

  assign cfg_ready        = 1'b1;
  assign out_mix_value    = acc_r;
  assign out_current_step = shown_step_r;
  assign out_playing      = tick_play_r;

  dsm_sample_ram #(
    .DEPTH (SMP_DEPTH),
    .AW    (SM_AW)
  ) u_sample_ram (
    .clk     (clk),
    .wr_en   (smp_wr),
    .wr_addr (smp_wr_addr),
    .wr_data (in_sample_value),
    .rd_en   (smp_rd),
    .rd_addr (smp_rd_addr),
    .rd_data (smp_q)
  );

  // pattern and sequence memory arrays
  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[pat_wr_addr] <= pat_wr_data;
    end
    if (pat_rd) begin
      mask_q_r <= pat_mem[pat_rd_addr];
    end
    if (seq_wr) begin
      seq_mem[seq_wr_addr] <= seq_wr_data;
    end
    if (seq_rd) begin
      seq_q_r <= seq_mem[seq_pos_r[SQ_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      play_r      <= 1'b0;
      tick_play_r <= 1'b0;
      pulse_r     <= '0;
      step_r      <= '0;
      seq_pos_r   <= '0;
      beat_r      <= BEAT_LENGTH_RESET;
      seq_len_r   <= SEQUENCE_LENGTH_RESET;
      pend_r      <= 1'b0;
      for (int k = 0; k < NUM_INSTRUMENTS; k++) begin
        len_r[k] <= '0;
        pos_r[k] <= '0;
        act_r[k] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      pend_r  <= smp_rd;

      if (clearing) begin
        clr_r <= clr_r + 1'b1;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BEAT_LENGTH:     beat_r    <= cfg_data;
          CFG_SEQUENCE_LENGTH: seq_len_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (accept) begin
        case (op)
          OP_TICK: begin
            shown_step_r <= step_r;
            tick_play_r  <= play_r;
            off_r        <= OFF_W'(pulse_r);
            j_r          <= '0;
            i_r          <= '0;
            acc_r        <= '0;
          end
          OP_PAD_TRIGGER: begin
            if ({1'b0, in_instrument} < INS_NUM && len_rd != '0) begin
              act_r[len_idx] <= 1'b1;
              pos_r[len_idx] <= '0;
            end
          end
          OP_PLAY_TOGGLE: begin
            play_r <= !play_r;
            if (play_r) begin
              pulse_r   <= '0;
              step_r    <= '0;
              seq_pos_r <= '0;
            end
          end
          OP_SAMPLE_LEN: begin
            if ({1'b0, in_instrument} < INS_NUM) begin
              len_r[len_idx] <= (in_sample_length > LEN_MAX) ? LEN_MAX : in_sample_length;
            end
          end
          default: ;
        endcase
      end else begin
        if (pend_r) begin
          acc_r <= acc_r + MIX_W'(smp_q);
        end
      end

      case (state_r)
        ST_SEQ: begin
          pat_r <= pat_sel;
        end
        ST_HIT: begin
          i_r <= i_last ? '0 : i_r + 1'b1;
          if (i_last) begin
            j_r   <= j_r + 1'b1;
            off_r <= off_r + OFF_W'(beat_r);
          end
        end
        ST_VOICE: begin
          i_r <= i_r + 1'b1;
          if (act_r[i_r]) begin
            // voice ends once its next position reaches the length
            if (pos_r[i_r] + 1'b1 >= len_rd) begin
              act_r[i_r] <= 1'b0;
              pos_r[i_r] <= '0;
            end else begin
              pos_r[i_r] <= pos_r[i_r] + 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (advance) begin
        if ({1'b0, pulse_r} + 17'd1 >= {1'b0, beat_r}) begin
          pulse_r <= '0;
          step_r  <= step_r + 1'b1;
          if (step_r == 4'hF) begin
            if ({1'b0, seq_pos_r} + 8'd1 >= eff_len) begin
              seq_pos_r <= '0;
            end else begin
              seq_pos_r <= seq_pos_r + 1'b1;
            end
          end
        end else begin
          pulse_r <= pulse_r + 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_result_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation != OP_TICK) |=> !busy)
    else $error("load operation left the block busy");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_TICK) |=> (busy && !out_valid))
    else $error("tick did not start its walk");

  a_read_source: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(state_r) == ST_HIT || $past(state_r) == ST_VOICE))
    else $error("sample read outside the mixing walk");
`endif

endmodule
